FILE: rtl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types, widths and constants of the HTTP response header stripper.
// ----------------------------------------------------------------------------
package hrs_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HdrW    = 13;
  localparam int unsigned ImgW    = 21;
  localparam int unsigned OffW    = 20;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgW    = 21;
  localparam int unsigned OutDataW = 56;

  // hard caps on the programmable limits
  localparam int unsigned HeaderMax = 4096;
  localparam int unsigned ImageMax  = 1048576;

  localparam logic [HdrW-1:0] HdrCap = HdrW'(HeaderMax);
  localparam logic [ImgW-1:0] ImgCap = ImgW'(ImageMax);

  // header offsets that matter for the status line
  localparam logic [HdrW-1:0] StatusEnd = HdrW'(12);

  // terminator detection
  localparam logic [23:0] CrLfCr = 24'h0D0A0D;
  localparam logic [7:0]  Lf     = 8'h0A;

  // phase codes as seen on the output
  typedef enum logic [PhaseW-1:0] {
    PhHeader    = 3'd0,
    PhBody      = 3'd1,
    PhBadStatus = 3'd2,
    PhHeaderBig = 3'd3,
    PhImageBig  = 3'd4
  } phase_e;

  // configuration register indexes
  typedef enum logic {
    CfgHeaderLimit = 1'b0,
    CfgImageLimit  = 1'b1
  } cfg_idx_e;

  // effective limits handed to the datapath
  typedef struct packed {
    logic [HdrW-1:0] hdr_lim;
    logic [ImgW-1:0] img_lim;
  } lim_t;

  // check one status line byte: "HTTP/1." then any two bytes (minor digit,
  // space), then "200"; offsets past the status digits always pass
  function automatic logic status_byte_ok(logic [3:0] pos, logic [ByteW-1:0] b);
    logic ok;
    ok = 1'b1;
    case (pos)
      4'd0:  ok = (b == "H");
      4'd1:  ok = (b == "T");
      4'd2:  ok = (b == "T");
      4'd3:  ok = (b == "P");
      4'd4:  ok = (b == "/");
      4'd5:  ok = (b == "1");
      4'd6:  ok = (b == ".");
      4'd9:  ok = (b == "2");
      4'd10: ok = (b == "0");
      4'd11: ok = (b == "0");
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/hrs_cfg.sv
// ----------------------------------------------------------------------------
// hrs_cfg
// Limit registers; each write is truncated to the field width, then capped.
// ----------------------------------------------------------------------------
module hrs_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  hrs_pkg::cfg_idx_e        addr_i,
  input  logic [hrs_pkg::CfgW-1:0] data_i,
  output hrs_pkg::lim_t            lim_o
);

  hrs_pkg::lim_t lim_d, lim_q;
  logic [hrs_pkg::HdrW-1:0] hdr_wr;
  logic [hrs_pkg::ImgW-1:0] img_wr;

  // truncate the written value to the field width ahead of the clamp
  assign hdr_wr = data_i[hrs_pkg::HdrW-1:0];
  assign img_wr = data_i[hrs_pkg::ImgW-1:0];

  always_comb begin
    lim_d = lim_q;
    if (wr_en_i) begin
      unique case (addr_i)
        hrs_pkg::CfgHeaderLimit:
          lim_d.hdr_lim = (hdr_wr < hrs_pkg::HdrCap) ? hdr_wr : hrs_pkg::HdrCap;
        hrs_pkg::CfgImageLimit:
          lim_d.img_lim = (img_wr < hrs_pkg::ImgCap) ? img_wr : hrs_pkg::ImgCap;
        default: lim_d = lim_q;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.hdr_lim <= hrs_pkg::HdrCap;
      lim_q.img_lim <= hrs_pkg::ImgCap;
    end else begin
      lim_q <= lim_d;
    end
  end

  assign lim_o = lim_q;

endmodule

FILE: rtl/http_response_header_stripper_core.sv
// ----------------------------------------------------------------------------
// http_response_header_stripper_core
// Strips the header of an HTTP response, checks for status 200 and passes
// the body bytes out with their image write offset.
// ----------------------------------------------------------------------------
// One response byte is taken per clock while the output is ready, and every
// byte yields one result transfer via the input and then the result register.
// The header/body state is updated once per byte, so the block keeps a full
// byte-per-clock rate as long as the output side is ready; output stalls back
// up into the input through the two register stages. A transfer with tuser
// set restarts a download and clears all state while the limit registers keep
// their values. Limits are written through the cfg channel (index 0 header
// limit, index 1 image limit); the user must do so only while the stream is
// idle, which the block does not enforce; writes are truncated, then capped.
module http_response_header_stripper_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [hrs_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]                   s_axis_tuser,   // [0] kind (restart)
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] body_byte, [27:8] write_offset, [30:28] phase,
  // [51:31] image_count, [55:52] zero
  output logic [hrs_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [0:0]                   m_axis_tuser,   // [0] body_valid
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_addr_i,
  input  logic [hrs_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned PadW = hrs_pkg::OutDataW - hrs_pkg::ByteW - hrs_pkg::OffW
                                 - hrs_pkg::PhaseW - hrs_pkg::ImgW;

  hrs_pkg::lim_t lim;
  hrs_pkg::cfg_idx_e cfg_idx;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = hrs_pkg::cfg_idx_e'(cfg_addr_i);

  hrs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_valid_i && cfg_ready_o),
    .addr_i  (cfg_idx),
    .data_i  (cfg_data_i),
    .lim_o   (lim)
  );

  // input register
  logic                     in_vld_q, in_vld_d;
  logic                     in_kind_q;
  logic [hrs_pkg::ByteW-1:0] in_byte_q;
  logic                     out_free, adv, in_xfer;

  // result register
  logic                      out_vld_q, out_vld_d;
  logic                      res_valid_q, res_valid_d;
  logic [hrs_pkg::ByteW-1:0]  res_byte_q, res_byte_d;
  logic [hrs_pkg::OffW-1:0]   res_off_q, res_off_d;

  // stripper state
  logic [hrs_pkg::HdrW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [23:0]               recent_q, recent_d;
  logic                      good_q, good_d;
  hrs_pkg::phase_e           mode_q, mode_d;
  logic [hrs_pkg::ImgW-1:0]  body_cnt_q, body_cnt_d;
  logic                      good_now;

  // handshake between the stages
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_kind_q <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
  end

  // per-byte state update
  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    recent_d    = recent_q;
    good_d      = good_q;
    mode_d      = mode_q;
    body_cnt_d  = body_cnt_q;
    res_valid_d = 1'b0;
    res_byte_d  = '0;
    res_off_d   = '0;
    good_now    = good_q;
    if (in_kind_q) begin
      hdr_cnt_d  = '0;
      recent_d   = '0;
      good_d     = 1'b1;
      mode_d     = hrs_pkg::PhHeader;
      body_cnt_d = '0;
    end else begin
      unique case (mode_q)
        hrs_pkg::PhHeader: begin
          if (hdr_cnt_q >= lim.hdr_lim) begin
            mode_d = hrs_pkg::PhHeaderBig;
          end else begin
            if (hdr_cnt_q < hrs_pkg::StatusEnd &&
                !hrs_pkg::status_byte_ok(hdr_cnt_q[3:0], in_byte_q)) begin
              good_now = 1'b0;
            end
            good_d    = good_now;
            hdr_cnt_d = hdr_cnt_q + 1'b1;
            // end of header: CR LF CR LF
            if (recent_q == hrs_pkg::CrLfCr && in_byte_q == hrs_pkg::Lf) begin
              if (hdr_cnt_d < hrs_pkg::StatusEnd || !good_now) begin
                mode_d = hrs_pkg::PhBadStatus;
              end else begin
                mode_d = hrs_pkg::PhBody;
              end
            end
            recent_d = {recent_q[15:0], in_byte_q};
          end
        end
        hrs_pkg::PhBody: begin
          if (body_cnt_q >= lim.img_lim) begin
            mode_d = hrs_pkg::PhImageBig;
          end else begin
            res_valid_d = 1'b1;
            res_byte_d  = in_byte_q;
            res_off_d   = body_cnt_q[hrs_pkg::OffW-1:0];
            body_cnt_d  = body_cnt_q + 1'b1;
          end
        end
        // error phases hold until restart
        default: mode_d = mode_q;
      endcase
    end
  end

  // state registers, advance once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q  <= '0;
      recent_q   <= '0;
      good_q     <= 1'b1;
      mode_q     <= hrs_pkg::PhHeader;
      body_cnt_q <= '0;
    end else if (adv) begin
      hdr_cnt_q  <= hdr_cnt_d;
      recent_q   <= recent_d;
      good_q     <= good_d;
      mode_q     <= mode_d;
      body_cnt_q <= body_cnt_d;
    end
  end

  // result valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // result payload; phase and count are read from the state registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_valid_q <= res_valid_d;
      res_byte_q  <= res_byte_d;
      res_off_q   <= res_off_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, body_cnt_q, mode_q, res_off_q, res_byte_q};

endmodule

FILE: rtl/hrs_checker.sv
// ----------------------------------------------------------------------------
// hrs_checker
// Port-level checks on the result stream of the header stripper.
// ----------------------------------------------------------------------------
module hrs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [hrs_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  logic [hrs_pkg::ByteW-1:0] body_byte;
  logic [hrs_pkg::OffW-1:0]  offset;
  logic [hrs_pkg::PhaseW-1:0] phase;
  logic [hrs_pkg::ImgW-1:0]  img_cnt;
  logic [hrs_pkg::OffW-1:0]  offset_next;

  // unpack the result fields
  assign body_byte   = m_axis_tdata[7:0];
  assign offset      = m_axis_tdata[27:8];
  assign phase       = m_axis_tdata[30:28];
  assign img_cnt     = m_axis_tdata[51:31];
  assign offset_next = offset + 1'b1;

  // a stalled result transfer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // body bytes only leave in body phase
  a_body_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> phase == hrs_pkg::PhBody)
    else $error("body byte outside body phase");

  // progress count runs one ahead of the write offset
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> img_cnt[hrs_pkg::OffW-1:0] == offset_next)
    else $error("image count and write offset disagree");

  // non-body results carry no byte and no offset
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> body_byte == '0 && offset == '0)
    else $error("non-body result carries payload");

endmodule

bind http_response_header_stripper_core hrs_checker u_hrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
